@@ rtl/lrd_pkg.sv @@
package lrd_pkg;

  localparam int unsigned MagicBytesDef = 5;
  localparam logic [31:0] CrcPoly       = 32'hEDB88320;
  localparam logic [31:0] CrcInit       = 32'hFFFFFFFF;

  typedef enum logic [3:0] {
    KIND_KEY_BYTE   = 4'd0,
    KIND_VALUE_BYTE = 4'd1,
    KIND_META_OK    = 4'd2,
    KIND_ENTRY_OK   = 4'd3,
    KIND_CLEAN_END  = 4'd4,
    KIND_TRUNCATED  = 4'd5,
    KIND_UNKNOWN    = 4'd6,
    KIND_BAD_HEADER = 4'd7,
    KIND_BAD_VER    = 4'd8,
    KIND_CRC_ERR    = 4'd9,
    KIND_LEN_ERR    = 4'd10
  } kind_e;

  typedef enum logic [1:0] {
    REG_MAGIC   = 2'd0,
    REG_VERSION = 2'd1,
    REG_META    = 2'd2,
    REG_ENTRY   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [39:0] magic;
    logic [15:0] version;
    logic [7:0]  meta_code;
    logic [7:0]  entry_code;
  } cfg_t;

  // One accepted byte yields at most a first result and optionally a trailing status.
  typedef struct packed {
    logic        two;
    kind_e       kind1;
    logic [7:0]  pay;
    logic [63:0] term;
    logic [63:0] idx;
    logic [31:0] vote;
    logic [7:0]  cmd;
    logic [15:0] klen;
    logic [31:0] vlen;
    kind_e       kind2;
  } ent_t;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

@@ rtl/lrd_parser.sv @@
module lrd_parser #(
  parameter int unsigned MAGIC_BYTES = lrd_pkg::MagicBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lrd_pkg::cfg_t cfg_i,
  input  logic          fire_i,
  input  logic [7:0]    byte_i,
  input  logic          eol_i,
  output logic          push_o,
  output lrd_pkg::ent_t ent_o
);
  import lrd_pkg::*;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_VERSION, PH_TYPE, PH_M_TERM, PH_M_VOTE, PH_M_CRC,
    PH_E_LEN, PH_E_TERM, PH_E_INDEX, PH_E_CMD, PH_E_KLEN, PH_E_KEY,
    PH_E_VLEN, PH_E_VAL, PH_E_CRC
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  fbc_q, fbc_d;
  logic [31:0] crc_q, crc_d;
  logic [63:0] shift_q, shift_d;
  logic [63:0] term_q, term_d;
  logic [63:0] index_q, index_d;
  logic [31:0] vote_q, vote_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] klen_q, klen_d;
  logic [31:0] vlen_q, vlen_d;
  logic [31:0] left_q, left_d;
  logic [31:0] dlen_q, dlen_d;
  logic        halted_q, halted_d;

  logic [63:0] acc;
  logic [3:0]  cnt1;
  logic [63:0] magic_ext;
  logic [7:0]  magic_byte;
  logic [33:0] len_sum;
  logic        f_valid, s_valid;
  ent_t        f;
  kind_e       s_kind;

  assign acc        = shift_q | ({56'd0, byte_i} << {fbc_q[2:0], 3'b000});
  assign cnt1       = fbc_q + 4'd1;
  assign magic_ext  = {24'd0, cfg_i.magic};
  assign magic_byte = magic_ext[{fbc_q[2:0], 3'b000} +: 8];
  assign len_sum    = 34'd23 + {18'd0, klen_q} + {2'd0, acc[31:0]};

  always_comb begin
    phase_d  = phase_q;  fbc_d   = fbc_q;   crc_d   = crc_q;  shift_d = shift_q;
    term_d   = term_q;   index_d = index_q; vote_d  = vote_q; cmd_d   = cmd_q;
    klen_d   = klen_q;   vlen_d  = vlen_q;  left_d  = left_q; dlen_d  = dlen_q;
    halted_d = halted_q;
    f        = '0;
    f.kind1  = KIND_KEY_BYTE;
    f.kind2  = KIND_CLEAN_END;
    f_valid  = 1'b0;
    s_valid  = 1'b0;
    s_kind   = KIND_CLEAN_END;

    if (!halted_q) begin
      case (phase_q)
        PH_MAGIC: begin
          if (byte_i != magic_byte) begin
            f_valid = 1'b1; f.kind1 = KIND_BAD_HEADER; halted_d = 1'b1;
          end else if (cnt1 >= 4'(MAGIC_BYTES)) begin
            fbc_d = '0; phase_d = PH_VERSION;
          end else begin
            fbc_d = cnt1;
          end
        end
        PH_VERSION: begin
          shift_d = acc; fbc_d = cnt1;
          if (cnt1 >= 4'd2) begin
            shift_d = '0; fbc_d = '0;
            if (acc[15:0] != cfg_i.version) begin
              f_valid = 1'b1; f.kind1 = KIND_BAD_VER; halted_d = 1'b1;
            end else begin
              phase_d = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          if (byte_i == cfg_i.meta_code || byte_i == cfg_i.entry_code) begin
            phase_d = (byte_i == cfg_i.meta_code) ? PH_M_TERM : PH_E_LEN;
            crc_d   = crc_byte(CrcInit, byte_i);
            shift_d = '0; fbc_d = '0;
          end else begin
            f_valid = 1'b1; f.kind1 = KIND_UNKNOWN; halted_d = 1'b1;
          end
        end
        PH_M_TERM, PH_E_TERM, PH_E_INDEX: begin
          crc_d = crc_byte(crc_q, byte_i);
          shift_d = acc; fbc_d = cnt1;
          if (cnt1 >= 4'd8) begin
            shift_d = '0; fbc_d = '0;
            if (phase_q == PH_E_INDEX) begin
              index_d = acc; phase_d = PH_E_CMD;
            end else begin
              term_d  = acc;
              phase_d = (phase_q == PH_M_TERM) ? PH_M_VOTE : PH_E_INDEX;
            end
          end
        end
        PH_M_VOTE, PH_E_LEN: begin
          crc_d = crc_byte(crc_q, byte_i);
          shift_d = acc; fbc_d = cnt1;
          if (cnt1 >= 4'd4) begin
            shift_d = '0; fbc_d = '0;
            if (phase_q == PH_M_VOTE) begin
              vote_d = acc[31:0]; phase_d = PH_M_CRC;
            end else begin
              dlen_d = acc[31:0]; phase_d = PH_E_TERM;
            end
          end
        end
        PH_M_CRC, PH_E_CRC: begin
          shift_d = acc; fbc_d = cnt1;
          if (cnt1 >= 4'd4) begin
            shift_d = '0; fbc_d = '0;
            f_valid = 1'b1;
            if (acc[31:0] != ~crc_q) begin
              f.kind1 = KIND_CRC_ERR; halted_d = 1'b1;
            end else begin
              phase_d = PH_TYPE;
              f.term  = term_q;
              if (phase_q == PH_M_CRC) begin
                f.kind1 = KIND_META_OK;
                f.vote  = vote_q;
              end else begin
                f.kind1 = KIND_ENTRY_OK;
                f.idx   = index_q;
                f.cmd   = cmd_q;
                f.klen  = klen_q;
                f.vlen  = vlen_q;
              end
            end
          end
        end
        PH_E_CMD: begin
          crc_d = crc_byte(crc_q, byte_i);
          cmd_d = byte_i; phase_d = PH_E_KLEN;
        end
        PH_E_KLEN: begin
          crc_d = crc_byte(crc_q, byte_i);
          shift_d = acc; fbc_d = cnt1;
          if (cnt1 >= 4'd2) begin
            shift_d = '0; fbc_d = '0;
            klen_d  = acc[15:0];
            left_d  = {16'd0, acc[15:0]};
            phase_d = (acc[15:0] != 16'd0) ? PH_E_KEY : PH_E_VLEN;
          end
        end
        PH_E_KEY, PH_E_VAL: begin
          crc_d   = crc_byte(crc_q, byte_i);
          f_valid = 1'b1;
          f.kind1 = (phase_q == PH_E_KEY) ? KIND_KEY_BYTE : KIND_VALUE_BYTE;
          f.pay   = byte_i;
          left_d  = left_q - 32'd1;
          if (left_q == 32'd1) begin
            phase_d = (phase_q == PH_E_KEY) ? PH_E_VLEN : PH_E_CRC;
          end
        end
        PH_E_VLEN: begin
          crc_d = crc_byte(crc_q, byte_i);
          shift_d = acc; fbc_d = cnt1;
          if (cnt1 >= 4'd4) begin
            shift_d = '0; fbc_d = '0;
            vlen_d  = acc[31:0];
            if ({2'd0, dlen_q} != len_sum) begin
              f_valid = 1'b1; f.kind1 = KIND_LEN_ERR; halted_d = 1'b1;
            end else begin
              left_d  = acc[31:0];
              phase_d = (acc[31:0] != 32'd0) ? PH_E_VAL : PH_E_CRC;
            end
          end
        end
        default: ;
      endcase

      if (eol_i && !halted_d) begin
        s_valid = 1'b1;
        if (phase_d == PH_TYPE) begin
          s_kind = KIND_CLEAN_END;
        end else if (phase_d == PH_MAGIC || phase_d == PH_VERSION) begin
          s_kind = KIND_BAD_HEADER;
        end else begin
          s_kind = KIND_TRUNCATED;
        end
      end
    end

    // end of image: parse state back to its reset value
    if (eol_i) begin
      phase_d = PH_MAGIC; fbc_d = '0; crc_d = CrcInit; shift_d = '0;
      term_d = '0; index_d = '0; vote_d = '0; cmd_d = '0; klen_d = '0;
      vlen_d = '0; left_d = '0; dlen_d = '0; halted_d = 1'b0;
    end

    ent_o = f;
    if (f_valid) begin
      ent_o.two   = s_valid;
      ent_o.kind2 = s_kind;
    end else begin
      ent_o.two   = 1'b0;
      ent_o.kind1 = s_kind;
    end
    push_o = fire_i && (f_valid || s_valid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC; fbc_q <= '0; crc_q <= CrcInit; shift_q <= '0;
      term_q <= '0; index_q <= '0; vote_q <= '0; cmd_q <= '0; klen_q <= '0;
      vlen_q <= '0; left_q <= '0; dlen_q <= '0; halted_q <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d; fbc_q <= fbc_d; crc_q <= crc_d; shift_q <= shift_d;
      term_q <= term_d; index_q <= index_d; vote_q <= vote_d; cmd_q <= cmd_d;
      klen_q <= klen_d; vlen_q <= vlen_d; left_q <= left_d; dlen_q <= dlen_d;
      halted_q <= halted_d;
    end
  end

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && halted_q) |-> !push_o)
    else $error("result produced while halted");
  a_eol_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && eol_i) |=> (phase_q == PH_MAGIC && !halted_q && fbc_q == 4'd0))
    else $error("parse state not restarted after end of log");
  a_eol_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && eol_i && !halted_q) |-> push_o)
    else $error("end of log without a result");
  a_fbc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fbc_q < 4'd8)
    else $error("field byte count out of range");

endmodule

@@ rtl/lrd_out_fifo.sv @@
module lrd_out_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lrd_pkg::ent_t ent_i,
  output logic          space_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [3:0]    kind_o,
  output logic [7:0]    pay_o,
  output logic [63:0]   term_o,
  output logic [63:0]   idx_o,
  output logic [31:0]   vote_o,
  output logic [7:0]    cmd_o,
  output logic [15:0]   klen_o,
  output logic [31:0]   vlen_o,
  output logic          last_o
);
  import lrd_pkg::*;

  ent_t       mem_q [2];
  logic       wr_q, rd_q, sub_q;
  logic [1:0] cnt_q;
  logic       pop, fire;
  ent_t       head;

  assign head    = mem_q[rd_q];
  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign fire    = valid_o && ready_i;
  assign last_o  = sub_q || !head.two;
  assign pop     = fire && last_o;

  // trailing status carries zero record fields
  always_comb begin
    kind_o = sub_q ? head.kind2 : head.kind1;
    pay_o  = sub_q ? '0 : head.pay;
    term_o = sub_q ? '0 : head.term;
    idx_o  = sub_q ? '0 : head.idx;
    vote_o = sub_q ? '0 : head.vote;
    cmd_o  = sub_q ? '0 : head.cmd;
    klen_o = sub_q ? '0 : head.klen;
    vlen_o = sub_q ? '0 : head.vlen;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; sub_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      if (fire) sub_q <= !last_o;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("result queue overflow");
  a_sub_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (valid_o && head.two))
    else $error("second result selected on a single-result entry");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o)
    else $error("push into full queue");

endmodule

@@ rtl/log_record_deframer_crc32.sv @@
// Channel | Handshake              | Payload
// in      | in_valid_i/in_ready_o  | in_byte_i, end_of_log_i
// out     | out_valid_o/out_ready_i| kind_o .. value_length_o, last_of_run_o
// cfg     | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// One byte request per cycle while a queue slot is free: the parse state step
// (CRC byte, field shift, compares) is combinational, results land in a
// 2-entry result queue. A byte giving two results (record/byte plus end status)
// is read out as two transfers; input throttles only when the queue is full.
// Reset clears parse state and loads register defaults; no clearing pass.
module log_record_deframer_crc32 #(
  parameter int unsigned MAGIC_BYTES = lrd_pkg::MagicBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_log_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [63:0] term_o,
  output logic [63:0] log_index_o,
  output logic signed [31:0] voted_for_o,
  output logic [7:0]  command_o,
  output logic [15:0] key_length_o,
  output logic [31:0] value_length_o,
  output logic        last_of_run_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [39:0] cfg_wdata_i
);
  import lrd_pkg::*;

  cfg_t        cfg_q;
  logic        in_fire;
  logic        push;
  ent_t        ent;
  logic [31:0] vote;

  // config registers, to be written only while idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic      <= '0;
      cfg_q.version    <= 16'd1;
      cfg_q.meta_code  <= 8'd1;
      cfg_q.entry_code <= 8'd2;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_MAGIC:   cfg_q.magic      <= cfg_wdata_i;
        REG_VERSION: cfg_q.version    <= cfg_wdata_i[15:0];
        REG_META:    cfg_q.meta_code  <= cfg_wdata_i[7:0];
        REG_ENTRY:   cfg_q.entry_code <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_fire = in_valid_i && in_ready_o;

  lrd_parser #(.MAGIC_BYTES(MAGIC_BYTES)) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .fire_i (in_fire),
    .byte_i (in_byte_i),
    .eol_i  (end_of_log_i),
    .push_o (push),
    .ent_o  (ent)
  );

  // results queue; a request is taken whenever a slot is free
  lrd_out_fifo u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent),
    .space_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .kind_o  (kind_o),
    .pay_o   (payload_byte_o),
    .term_o  (term_o),
    .idx_o   (log_index_o),
    .vote_o  (vote),
    .cmd_o   (command_o),
    .klen_o  (key_length_o),
    .vlen_o  (value_length_o),
    .last_o  (last_of_run_o)
  );

  assign voted_for_o = signed'(vote);

endmodule

@@ bench/log_record_deframer_crc32_test.sv @@
`timescale 1ns / 100ps

module log_record_deframer_crc32_test;
  import lrd_pkg::*;

  localparam int MagicLen = 5;
  localparam int CycleLimit = 600000;
  localparam int HoldLen = 400;

  // Parser phases of the local predictor
  typedef enum logic [3:0] {
    P_MAGIC, P_VER, P_TYPE, P_M_TERM, P_M_VOTE, P_M_CRC, P_E_LEN, P_E_TERM,
    P_E_INDEX, P_E_CMD, P_E_KLEN, P_E_KEY, P_E_VLEN, P_E_VAL, P_E_CRC
  } parse_phase_e;

  // Shapes of generated log images
  typedef enum int {
    IMG_GOOD, IMG_BAD_MAGIC, IMG_BAD_VER, IMG_UNKNOWN, IMG_CRC_FLIP, IMG_LEN_BAD,
    IMG_TRUNC, IMG_HDR_CUT, IMG_NOISE
  } img_shape_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eol;
  } log_byte_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pay;
    logic [63:0] term;
    logic [63:0] idx;
    logic [31:0] vote;
    logic [7:0]  cmd;
    logic [15:0] klen;
    logic [31:0] vlen;
    logic        last;
  } rec_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = '0;
  logic        end_of_log_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic [63:0] term_o;
  logic [63:0] log_index_o;
  logic signed [31:0] voted_for_o;
  logic [7:0]  command_o;
  logic [15:0] key_length_o;
  logic [31:0] value_length_o;
  logic        last_of_run_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [39:0] cfg_wdata_i = '0;

  log_record_deframer_crc32 dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Local register copies, updated alongside each write
  logic [39:0] magic_cfg = '0;
  logic [15:0] version_cfg = 16'd1;
  logic [7:0]  meta_code_cfg = 8'd1;
  logic [7:0]  entry_code_cfg = 8'd2;

  // Predictor state
  parse_phase_e ph;
  int unsigned  fcount;
  logic [31:0]  crc_acc;
  logic [63:0]  shift_acc;
  logic [63:0]  h_term, h_index;
  logic [31:0]  h_vote, h_vlen, bytes_left, decl_len;
  logic [7:0]   h_cmd;
  logic [15:0]  h_klen;
  logic         stopped;

  log_byte_t   byte_q[$];      // requests waiting for the driver
  rec_result_t result_q[$];    // results still owed by the block
  log_byte_t   img[$];         // image under construction
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  bit          in_burst = 1'b0, out_burst = 1'b0;

  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_parse();
    ph = P_MAGIC; fcount = 0; crc_acc = '1; shift_acc = '0;
    h_term = '0; h_index = '0; h_vote = '0; h_cmd = '0; h_klen = '0; h_vlen = '0;
    bytes_left = '0; decl_len = '0; stopped = 1'b0;
  endfunction

  // Collects one byte of a little-endian field; true once width bytes are in.
  function automatic bit gather(logic [7:0] b, int unsigned width);
    shift_acc |= 64'(b) << ((fcount & 7) * 8);
    fcount++;
    return fcount >= width;
  endfunction

  function automatic logic [63:0] take_field();
    logic [63:0] v;
    v = shift_acc; shift_acc = '0; fcount = 0;
    return v;
  endfunction

  function automatic rec_result_t blank(kind_e k);
    rec_result_t r;
    r = '0; r.kind = k;
    return r;
  endfunction

  // Expected results of one accepted byte, appended to result_q.
  function automatic void predict_byte(logic [7:0] b, logic eol);
    rec_result_t out[$];
    rec_result_t r;
    logic [63:0] v;
    if (!stopped) begin
      case (ph)
        P_MAGIC: begin
          if (b != 8'(magic_cfg >> ((fcount & 7) * 8))) begin
            out.insert(out.size(), blank(KIND_BAD_HEADER)); stopped = 1;
          end else begin
            fcount++;
            if (fcount >= MagicLen) begin fcount = 0; ph = P_VER; end
          end
        end
        P_VER: if (gather(b, 2)) begin
          if (16'(take_field()) != version_cfg) begin
            out.insert(out.size(), blank(KIND_BAD_VER)); stopped = 1;
          end else ph = P_TYPE;
        end
        P_TYPE: begin
          if (b == meta_code_cfg) ph = P_M_TERM;
          else if (b == entry_code_cfg) ph = P_E_LEN;
          else begin out.insert(out.size(), blank(KIND_UNKNOWN)); stopped = 1; end
          if (!stopped) begin
            crc_acc = crc32_step('1, b); shift_acc = '0; fcount = 0;
          end
        end
        P_M_TERM: begin
          crc_acc = crc32_step(crc_acc, b);
          if (gather(b, 8)) begin h_term = take_field(); ph = P_M_VOTE; end
        end
        P_M_VOTE: begin
          crc_acc = crc32_step(crc_acc, b);
          if (gather(b, 4)) begin h_vote = 32'(take_field()); ph = P_M_CRC; end
        end
        P_M_CRC: if (gather(b, 4)) begin
          if (32'(take_field()) != ~crc_acc) begin
            out.insert(out.size(), blank(KIND_CRC_ERR)); stopped = 1;
          end else begin
            r = blank(KIND_META_OK); r.term = h_term; r.vote = h_vote;
            out.insert(out.size(), r); ph = P_TYPE;
          end
        end
        P_E_LEN: begin
          crc_acc = crc32_step(crc_acc, b);
          if (gather(b, 4)) begin decl_len = 32'(take_field()); ph = P_E_TERM; end
        end
        P_E_TERM: begin
          crc_acc = crc32_step(crc_acc, b);
          if (gather(b, 8)) begin h_term = take_field(); ph = P_E_INDEX; end
        end
        P_E_INDEX: begin
          crc_acc = crc32_step(crc_acc, b);
          if (gather(b, 8)) begin h_index = take_field(); ph = P_E_CMD; end
        end
        P_E_CMD: begin
          crc_acc = crc32_step(crc_acc, b); h_cmd = b; ph = P_E_KLEN;
        end
        P_E_KLEN: begin
          crc_acc = crc32_step(crc_acc, b);
          if (gather(b, 2)) begin
            h_klen = 16'(take_field()); bytes_left = 32'(h_klen);
            ph = (bytes_left != 0) ? P_E_KEY : P_E_VLEN;
          end
        end
        P_E_KEY: begin
          crc_acc = crc32_step(crc_acc, b);
          r = blank(KIND_KEY_BYTE); r.pay = b; out.insert(out.size(), r);
          bytes_left--;
          if (bytes_left == 0) ph = P_E_VLEN;
        end
        P_E_VLEN: begin
          crc_acc = crc32_step(crc_acc, b);
          if (gather(b, 4)) begin
            h_vlen = 32'(take_field());
            v = 64'd23 + 64'(h_klen) + 64'(h_vlen);
            if (64'(decl_len) != v) begin
              out.insert(out.size(), blank(KIND_LEN_ERR)); stopped = 1;
            end else begin
              bytes_left = h_vlen;
              ph = (bytes_left != 0) ? P_E_VAL : P_E_CRC;
            end
          end
        end
        P_E_VAL: begin
          crc_acc = crc32_step(crc_acc, b);
          r = blank(KIND_VALUE_BYTE); r.pay = b; out.insert(out.size(), r);
          bytes_left--;
          if (bytes_left == 0) ph = P_E_CRC;
        end
        P_E_CRC: if (gather(b, 4)) begin
          if (32'(take_field()) != ~crc_acc) begin
            out.insert(out.size(), blank(KIND_CRC_ERR)); stopped = 1;
          end else begin
            r = blank(KIND_ENTRY_OK); r.term = h_term; r.idx = h_index; r.cmd = h_cmd;
            r.klen = h_klen; r.vlen = h_vlen; out.insert(out.size(), r); ph = P_TYPE;
          end
        end
        default: ;
      endcase
      // end-of-image status unless an error was just reported
      if (eol && !stopped) begin
        if (ph == P_TYPE) out.insert(out.size(), blank(KIND_CLEAN_END));
        else if (ph == P_MAGIC || ph == P_VER) out.insert(out.size(), blank(KIND_BAD_HEADER));
        else out.insert(out.size(), blank(KIND_TRUNCATED));
      end
    end
    if (eol) clear_parse();
    if (out.size() > 0) out[out.size() - 1].last = 1'b1;
    result_q = {result_q, out};
  endfunction

  // ---------------------------------------------------------------------------
  // Image construction
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void put_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) img.insert(img.size(), '{data: 8'(v >> (8 * i)), eol: 1'b0});
  endfunction

  function automatic void add_record(bit len_bad);
    logic [31:0] c;
    int s, klen, vlen;
    s = img.size();
    if ($urandom_range(0, 2) == 0) begin
      put_le(64'(meta_code_cfg), 1); put_le(pick64(), 8); put_le(pick64(), 4);
    end else begin
      klen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      vlen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      put_le(64'(entry_code_cfg), 1);
      put_le(64'(23 + klen + vlen + (len_bad ? $urandom_range(1, 3) : 0)), 4);
      put_le(pick64(), 8); put_le(pick64(), 8); put_le(64'($urandom), 1);
      put_le(64'(klen), 2);
      for (int i = 0; i < klen; i++) put_le(64'($urandom), 1);
      put_le(64'(vlen), 4);
      for (int i = 0; i < vlen; i++) put_le(64'($urandom), 1);
    end
    c = '1;
    for (int i = s; i < img.size(); i++) c = crc32_step(c, img[i].data);
    put_le(64'(~c), 4);
  endfunction

  function automatic void queue_image(img_shape_e shape);
    int n, pos;
    logic [7:0] t;
    img.delete();
    if (shape == IMG_NOISE) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) put_le(64'($urandom), 1);
    end else begin
      put_le(64'(magic_cfg), MagicLen);
      put_le(64'(version_cfg), 2);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) add_record(1'b0);
      case (shape)
        IMG_BAD_MAGIC: begin
          pos = $urandom_range(0, MagicLen - 1);
          img[pos].data ^= 8'(1 << $urandom_range(0, 7));
        end
        IMG_BAD_VER: img[MagicLen].data ^= 8'(1 << $urandom_range(0, 7));
        IMG_UNKNOWN: begin
          do t = 8'($urandom); while (t == meta_code_cfg || t == entry_code_cfg);
          put_le(64'(t), 1); put_le(64'($urandom), $urandom_range(0, 4));
        end
        IMG_CRC_FLIP: begin
          pos = img.size(); add_record(1'b0);
          pos = $urandom_range(pos, img.size() - 1);
          img[pos].data ^= 8'(1 << $urandom_range(0, 7));
        end
        IMG_LEN_BAD: add_record(1'b1);
        IMG_TRUNC: begin
          add_record(1'b0);
          n = $urandom_range(MagicLen + 3, img.size() - 1);
          while (img.size() > n) void'(img.pop_back());
        end
        IMG_HDR_CUT: while (img.size() > MagicLen + 1) void'(img.pop_back());
        default: ;
      endcase
      if (shape == IMG_HDR_CUT) begin
        n = $urandom_range(1, MagicLen + 1);
        while (img.size() > n) void'(img.pop_back());
      end
    end
    img[img.size() - 1].eol = 1'b1;
    byte_q = {byte_q, img};
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one request at a time, random gap drawn per request
  // ---------------------------------------------------------------------------
  int unsigned in_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    log_byte_t   nb;
    int unsigned g;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
    end else begin
      g = in_gap;
      if (in_valid_i && in_ready_o) predict_byte(in_byte_i, end_of_log_i);
      if (!in_valid_i || in_ready_o) begin
        if (g > 0) begin
          g--;
          in_valid_i <= 1'b0;
        end else if (byte_q.size() > 0) begin
          nb = byte_q.pop_front();
          in_byte_i <= nb.data;
          end_of_log_i <= nb.eol;
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 99) == 0) in_burst = ~in_burst;
          g = in_burst ? 0 : $urandom_range(0, 13);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      in_gap <= g;
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off: once, while plenty of requests are still pending
  // ---------------------------------------------------------------------------
  int unsigned hold_cnt = 0;
  bit          hold_off = 1'b0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (hold_off) begin
      if (hold_cnt >= HoldLen) begin
        hold_off <= 1'b0;
        hold_done <= 1'b1;
      end
      hold_cnt <= hold_cnt + 1;
    end else if (!hold_done && rst_ni && cycle_cnt >= 2000 && byte_q.size() > 100) begin
      hold_off <= 1'b1;
      hold_cnt <= 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stall per result, plus the hold-off window
  // ---------------------------------------------------------------------------
  int unsigned out_stall = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    rec_result_t e;
    int unsigned st;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall <= 0;
    end else begin
      st = out_stall;
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result kind=%0d at %0t", kind_o, $realtime);
        end else begin
          e = result_q.pop_front();
          if (kind_o !== e.kind || payload_byte_o !== e.pay || term_o !== e.term ||
              log_index_o !== e.idx || voted_for_o !== e.vote || command_o !== e.cmd ||
              key_length_o !== e.klen || value_length_o !== e.vlen ||
              last_of_run_o !== e.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  exp kind=%0d pay=%h term=%h idx=%h vote=%h cmd=%h kl=%h vl=%h last=%b",
                       e.kind, e.pay, e.term, e.idx, e.vote, e.cmd, e.klen, e.vlen, e.last);
              $display("  got kind=%0d pay=%h term=%h idx=%h vote=%h cmd=%h kl=%h vl=%h last=%b",
                       kind_o, payload_byte_o, term_o, log_index_o, voted_for_o, command_o,
                       key_length_o, value_length_o, last_of_run_o);
            end
          end
        end
        if ($urandom_range(0, 99) == 0) out_burst = ~out_burst;
        st = out_burst ? 0 : $urandom_range(0, 13);
      end else if (st > 0) begin
        st--;
      end
      out_stall <= st;
      out_ready_i <= (st == 0) && !hold_off;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Wait until every request is in and every result is out, then let it settle.
  task automatic drain();
    while (byte_q.size() > 0 || in_valid_i || result_q.size() > 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [39:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MAGIC:   magic_cfg = val;
      REG_VERSION: version_cfg = val[15:0];
      REG_META:    meta_code_cfg = val[7:0];
      default:     entry_code_cfg = val[7:0];
    endcase
  endtask

  task automatic set_regs(logic [39:0] m, logic [15:0] v, logic [7:0] mc, logic [7:0] ec);
    write_reg(REG_MAGIC, m);
    write_reg(REG_VERSION, 40'(v));
    write_reg(REG_META, 40'(mc));
    write_reg(REG_ENTRY, 40'(ec));
  endtask

  // Random images until about n requests have been queued
  task automatic random_images(int n);
    int target;
    int r;
    target = byte_q.size() + n;
    while (byte_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) queue_image(IMG_GOOD);
      else if (r < 62) queue_image(IMG_CRC_FLIP);
      else if (r < 68) queue_image(IMG_TRUNC);
      else if (r < 73) queue_image(IMG_LEN_BAD);
      else if (r < 78) queue_image(IMG_UNKNOWN);
      else if (r < 83) queue_image(IMG_BAD_VER);
      else if (r < 88) queue_image(IMG_BAD_MAGIC);
      else if (r < 93) queue_image(IMG_HDR_CUT);
      else queue_image(IMG_NOISE);
    end
  endtask

  initial begin
    clear_parse();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default codes, magic rewritten with its reset value
    set_regs(40'h0, 16'd1, 8'd1, 8'd2);
    // directed: wrong first magic byte, header cut short, header-only image,
    // unknown record type
    byte_q.insert(byte_q.size(), '{data: 8'h5a, eol: 1'b1});
    queue_image(IMG_HDR_CUT);
    img.delete();
    put_le(64'(magic_cfg), MagicLen); put_le(64'(version_cfg), 2);
    img[img.size() - 1].eol = 1'b1;
    byte_q = {byte_q, img};
    queue_image(IMG_UNKNOWN);
    random_images(250);
    drain();

    // extremes
    set_regs('1, 16'hffff, 8'hff, 8'h00);
    random_images(260);
    drain();
    set_regs(40'h00_0000_0000, 16'h0000, 8'h00, 8'hff);
    random_images(260);
    drain();

    // equal type codes: every typed record is taken as metadata
    set_regs({$urandom, 8'($urandom)}, 16'($urandom), 8'h33, 8'h33);
    random_images(200);
    drain();

    set_regs({$urandom, 8'($urandom)}, 16'($urandom), 8'($urandom_range(0, 127)),
             8'($urandom_range(128, 255)));
    random_images(300);
    drain();

    set_regs({$urandom, 8'($urandom)}, 16'd1, 8'd1, 8'd2);
    random_images(300);
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
